// ===== hw/rtl/svu_pkg.sv =====
package svu_pkg;

	localparam int EXP_STEPS = 12;
	localparam int LN_STEPS  = 12;

	localparam logic [16:0]        EXP_LOG2E = 17'd94548;  // log2(e) in Q16
	localparam logic [15:0]        LN_TWO    = 16'd45426;  // ln(2) in Q16
	localparam logic [16:0]        EXP_ONE   = 17'h10000;
	localparam logic [15:0]        PROB_MAX  = 16'hFFFF;
	localparam logic [23:0]        LN_FLOOR  = 24'h010000;
	localparam logic signed [15:0] SCORE_MIN = 16'sh8000;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SUM_RD,
		BK_SUM_GO,
		BK_SUM_WAIT,
		BK_LN_GO,
		BK_LN_WAIT,
		BK_EM_RD,
		BK_EM_GO,
		BK_EM_WAIT,
		BK_EM_PUSH
	} back_state_t;

	// handoff from front to back: one closed vector waiting in the store
	typedef struct packed {
		logic               valid;
		logic signed [15:0] max;
	} job_t;

	// Q16 values of 2^-(2^-(12-i))
	function automatic logic [15:0] pow2_neg_frac(input logic [3:0] i);
		logic [15:0] c;
		unique case (i)
			4'd0:    c = 16'd65525;
			4'd1:    c = 16'd65514;
			4'd2:    c = 16'd65492;
			4'd3:    c = 16'd65447;
			4'd4:    c = 16'd65359;
			4'd5:    c = 16'd65182;
			4'd6:    c = 16'd64830;
			4'd7:    c = 16'd64132;
			4'd8:    c = 16'd62757;
			4'd9:    c = 16'd60097;
			4'd10:   c = 16'd55108;
			4'd11:   c = 16'd46341;
			default: c = 16'd65535;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/svu_exp.sv =====
module svu_exp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [23:0] d,
	output logic               done,
	output logic [16:0]        result
);

	logic        busy_q;
	logic [3:0]  step_q;
	logic [23:0] mag_q;
	logic [24:0] t_q;
	logic [16:0] acc_q;
	logic        done_q;
	logic [16:0] result_q;

	logic [23:0] mag_in;
	logic [40:0] prod;
	logic [40:0] prod_rnd;
	logic [3:0]  bit_idx;
	logic [11:0] frac;
	logic [32:0] mul;
	logic [32:0] mul_rnd;
	logic [12:0] n;
	logic [4:0]  nsh;
	logic [17:0] rnd_sum;
	logic [17:0] shifted;
	logic [16:0] final_val;

	// positive arguments clamp to zero
	assign mag_in   = d[23] ? (~$unsigned(d) + 24'd1) : 24'd0;
	assign prod     = {17'd0, mag_q} * {24'd0, svu_pkg::EXP_LOG2E};
	assign prod_rnd = prod + 41'd32768;

	assign bit_idx = step_q - 4'd1;
	assign frac    = t_q[11:0];
	assign mul     = {16'd0, acc_q} * {17'd0, svu_pkg::pow2_neg_frac(bit_idx)};
	assign mul_rnd = mul + 33'd32768;

	assign n       = t_q[24:12];
	assign nsh     = n[4:0];
	assign rnd_sum = {1'b0, acc_q} + (18'd1 << (nsh - 5'd1));
	assign shifted = rnd_sum >> nsh;

	always_comb begin
		if (n > 13'd16) begin
			final_val = 17'd0;
		end else if (nsh == 5'd0) begin
			final_val = acc_q;
		end else begin
			final_val = shifted[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 4'd0;
			end else if (busy_q) begin
				if (step_q == 4'(svu_pkg::EXP_STEPS + 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
			acc_q <= svu_pkg::EXP_ONE;
		end else if (busy_q) begin
			if (step_q == 4'd0) begin
				t_q <= prod_rnd[40:16];
			end else if (step_q == 4'(svu_pkg::EXP_STEPS + 1)) begin
				result_q <= final_val;
			end else if (frac[bit_idx]) begin
				acc_q <= mul_rnd[32:16];
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hw/rtl/svu_ln.sv =====
module svu_ln (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] s,
	output logic        done,
	output logic [15:0] result
);

	logic        busy_q;
	logic        norm_q;
	logic [3:0]  step_q;
	logic [23:0] s_q;
	logic [2:0]  k_q;
	logic [31:0] m_q;
	logic [11:0] frac_q;
	logic        done_q;
	logic [15:0] result_q;

	logic [63:0] sq;
	logic [31:0] mn;
	logic [14:0] log2v;
	logic [31:0] lp;

	assign sq    = {32'd0, m_q} * {32'd0, m_q};
	assign mn    = sq[61:30];
	assign log2v = {k_q, frac_q};
	assign lp    = {17'd0, log2v} * {16'd0, svu_pkg::LN_TWO} + 32'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			norm_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				norm_q <= 1'b1;
				step_q <= 4'd0;
			end else if (busy_q) begin
				if (norm_q) begin
					if (s_q[23]) begin
						norm_q <= 1'b0;
					end
				end else if (step_q == 4'(svu_pkg::LN_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	// normalize one bit a cycle, then one squaring a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			s_q    <= (s < svu_pkg::LN_FLOOR) ? svu_pkg::LN_FLOOR : s;
			k_q    <= 3'd7;
			frac_q <= 12'd0;
		end else if (busy_q) begin
			if (norm_q) begin
				if (s_q[23]) begin
					m_q <= {1'b0, s_q, 7'd0};
				end else begin
					s_q <= {s_q[22:0], 1'b0};
					k_q <= k_q - 3'd1;
				end
			end else if (step_q == 4'(svu_pkg::LN_STEPS)) begin
				result_q <= lp[31:16];
			end else begin
				m_q    <= mn[31] ? {1'b0, mn[31:1]} : mn;
				frac_q <= {frac_q[10:0], mn[31]};
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hw/rtl/svu_front.sv =====
module svu_front #(
	parameter int MAX_LEN = 16,
	parameter int CW      = 5,
	parameter int AW      = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,
	input  logic                 s_tlast,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [15:0]   rd_data,
	output svu_pkg::job_t        job,
	output logic [CW-1:0]        job_count,
	input  logic                 job_done
);

	logic [CW-1:0]      count_q;
	logic signed [15:0] max_q;
	logic               job_valid_q;
	logic signed [15:0] job_max_q;
	logic [CW-1:0]      job_count_q;
	logic signed [15:0] mem [MAX_LEN];
	logic signed [15:0] rd_data_q;

	logic               accept;
	logic [CW-1:0]      count_inc;
	logic               close;
	logic signed [15:0] score;
	logic signed [15:0] max_new;

	// the store is shared with the back end, so hold off while a vector is pending
	assign s_tready  = !job_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign count_inc = count_q + CW'(1);
	assign close     = s_tlast || (count_inc == CW'(MAX_LEN));
	assign score     = $signed(s_tdata);
	assign max_new   = (score > max_q) ? score : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			max_q       <= svu_pkg::SCORE_MIN;
			job_valid_q <= 1'b0;
		end else begin
			if (job_done) begin
				job_valid_q <= 1'b0;
			end
			if (accept) begin
				if (close) begin
					count_q     <= '0;
					max_q       <= svu_pkg::SCORE_MIN;
					job_valid_q <= 1'b1;
				end else begin
					count_q <= count_inc;
					max_q   <= max_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && close) begin
			job_max_q   <= max_new;
			job_count_q <= count_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[count_q[AW-1:0]] <= score;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data   = rd_data_q;
	assign job       = '{valid: job_valid_q, max: job_max_q};
	assign job_count = job_count_q;

endmodule

// ===== hw/rtl/svu_back.sv =====
module svu_back #(
	parameter int CW = 5,
	parameter int AW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  svu_pkg::job_t      job,
	input  logic [CW-1:0]      job_count,
	output logic               job_done,
	output logic [AW-1:0]      rd_addr,
	input  logic signed [15:0] rd_data,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,
	output logic               m_tlast
);

	svu_pkg::back_state_t state_q, state_d;

	logic [CW-1:0]      idx_q;
	logic [23:0]        sum_q;
	logic signed [23:0] offset_q;
	logic [15:0]        pend_prob_q;
	logic               pend_last_q;
	logic               out_valid_q;
	logic [15:0]        out_data_q;
	logic               out_last_q;

	logic               last_idx;
	logic               out_free;
	logic               load_out;
	logic signed [16:0] diff;
	logic signed [23:0] d_sum;
	logic signed [23:0] d_em;
	logic signed [23:0] exp_d;
	logic               exp_start;
	logic               exp_done;
	logic [16:0]        exp_res;
	logic               ln_start;
	logic               ln_done;
	logic [15:0]        ln_res;

	assign rd_addr  = idx_q[AW-1:0];
	assign last_idx = (idx_q == job_count - CW'(1));
	assign out_free = !out_valid_q || m_tready;

	assign diff  = {rd_data[15], rd_data} - {job.max[15], job.max};
	assign d_sum = {{3{diff[16]}}, diff, 4'd0};
	assign d_em  = {{4{rd_data[15]}}, rd_data, 4'd0} - offset_q;
	assign exp_d = (state_q == svu_pkg::BK_SUM_GO) ? d_sum : d_em;

	svu_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.d      (exp_d),
		.done   (exp_done),
		.result (exp_res)
	);

	svu_ln u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ln_start),
		.s      (sum_q),
		.done   (ln_done),
		.result (ln_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			svu_pkg::BK_IDLE:     if (job.valid) state_d = svu_pkg::BK_SUM_RD;
			svu_pkg::BK_SUM_RD:   state_d = svu_pkg::BK_SUM_GO;
			svu_pkg::BK_SUM_GO:   state_d = svu_pkg::BK_SUM_WAIT;
			svu_pkg::BK_SUM_WAIT: begin
				if (exp_done) state_d = last_idx ? svu_pkg::BK_LN_GO : svu_pkg::BK_SUM_RD;
			end
			svu_pkg::BK_LN_GO:    state_d = svu_pkg::BK_LN_WAIT;
			svu_pkg::BK_LN_WAIT:  if (ln_done) state_d = svu_pkg::BK_EM_RD;
			svu_pkg::BK_EM_RD:    state_d = svu_pkg::BK_EM_GO;
			svu_pkg::BK_EM_GO:    state_d = svu_pkg::BK_EM_WAIT;
			svu_pkg::BK_EM_WAIT:  if (exp_done) state_d = svu_pkg::BK_EM_PUSH;
			svu_pkg::BK_EM_PUSH: begin
				if (out_free) state_d = last_idx ? svu_pkg::BK_IDLE : svu_pkg::BK_EM_RD;
			end
			default:              state_d = svu_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		exp_start = (state_q == svu_pkg::BK_SUM_GO) || (state_q == svu_pkg::BK_EM_GO);
		ln_start  = (state_q == svu_pkg::BK_LN_GO);
		load_out  = (state_q == svu_pkg::BK_EM_PUSH) && out_free;
		job_done  = load_out && last_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svu_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			svu_pkg::BK_IDLE: begin
				idx_q <= '0;
				sum_q <= '0;
			end
			svu_pkg::BK_SUM_WAIT: begin
				if (exp_done) begin
					sum_q <= sum_q + {7'd0, exp_res};
					idx_q <= last_idx ? '0 : idx_q + CW'(1);
				end
			end
			svu_pkg::BK_LN_WAIT: begin
				if (ln_done) begin
					offset_q <= {{4{job.max[15]}}, job.max, 4'd0} + $signed({8'd0, ln_res});
				end
			end
			svu_pkg::BK_EM_WAIT: begin
				if (exp_done) begin
					pend_prob_q <= exp_res[16] ? svu_pkg::PROB_MAX : exp_res[15:0];
					pend_last_q <= last_idx;
				end
			end
			svu_pkg::BK_EM_PUSH: begin
				if (out_free) begin
					out_data_q <= pend_prob_q;
					out_last_q <= pend_last_q;
					idx_q      <= idx_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hw/rtl/softmax_vector_unit.sv =====
// Softmax over a vector of signed Q7.8 scores, log-sum-exp form.
// Input stream (s_*): one score per request, s_tlast on the final element.
// A vector also closes when MAX_LEN elements have been taken.
// Output stream (m_*): one unsigned Q0.16 probability per element, in
// input order, saturated at 65535, m_tlast on the last one.
// Loading accepts one element per cycle while s_tready is high. Once a vector closes, s_tready drops
// until the last probability of that vector sits in the output register.
// The back end then walks the store twice through one shared exp unit:
// a sum pass over every element, then ln of the sum (normalize shifts
// and twelve squarings), then an emit pass over every element.
// A stalled m_tready holds the output register and the back end waits in
// front of it; loading of the next vector resumes once the last probability
// of the pending one is in the output register. Reset empties the store and
// drops both valid flags.
module softmax_vector_unit #(
	parameter int MAX_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] score
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] probability
	output logic        m_tlast
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	svu_pkg::job_t      job;
	logic [CW-1:0]      job_count;
	logic               job_done;
	logic [AW-1:0]      rd_addr;
	logic signed [15:0] rd_data;

	svu_front #(
		.MAX_LEN (MAX_LEN),
		.CW      (CW),
		.AW      (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.job       (job),
		.job_count (job_count),
		.job_done  (job_done)
	);

	svu_back #(
		.CW (CW),
		.AW (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_count (job_count),
		.job_done  (job_done),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== hw/rtl/svu_checker.sv =====
module svu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed under stall");

	// a closing request drops s_tready
	a_close_locks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input open right after vector close");

	// a fresh non-final result means a vector is still being processed
	a_busy_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && !m_tlast |-> !s_tready)
		else $error("input open while vector mid-emit");

endmodule

bind softmax_vector_unit svu_checker u_svu_checker (.*);
